// ===== rtl/pds_pkg.sv =====
// Package of the PLL divider search block: widths, limits, the analog band
// table and the divider request word. No dependencies.
`timescale 1ns / 1ps
package pds_pkg;

  localparam int MAX_LANES = 4;
  localparam int DIV_W     = 44;
  localparam int DVSR_W    = 28;
  localparam int CNT_W     = $clog2(DIV_W);

  localparam logic [DIV_W-1:0] FVCO_LO    = DIV_W'(320000000);
  localparam logic [DIV_W-1:0] FVCO_HI    = DIV_W'(1250000000);
  localparam logic [DIV_W-1:0] MULT_LO    = DIV_W'(64);
  localparam logic [DIV_W-1:0] MULT_HI    = DIV_W'(625);
  localparam logic [7:0]       PREDIV_CAP = 8'd128;
  localparam logic [DVSR_W-1:0] NMIN_DIV  = DVSR_W'(8000000);
  localparam logic [DVSR_W-1:0] NMAX_DIV  = DVSR_W'(2000000);
  localparam logic [DVSR_W-1:0] MHZ       = DVSR_W'(1000000);

  localparam logic [0:0] REG_REF_CLK   = 1'b0;
  localparam logic [0:0] REG_MAX_LANES = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [5:0] vco;
    logic [7:0] cp;
    logic [1:0] gmp;
    logic [5:0] integ;
    logic [5:0] prop;
  } band_t;

  localparam int NUM_ROWS = 11;
  localparam logic [30:0] BAND_LIMIT [NUM_ROWS] = '{
    31'd55000000, 31'd82000000, 31'd110000000, 31'd165000000, 31'd220000000,
    31'd330000000, 31'd440000000, 31'd660000000, 31'd1149000000,
    31'd1152000000, 31'd1250000000
  };
  localparam logic [5:0] BAND_VCO [NUM_ROWS] = '{
    6'h3f, 6'h37, 6'h2f, 6'h27, 6'h1f, 6'h17, 6'h0f, 6'h07, 6'h03, 6'h01, 6'h01
  };

  function automatic band_t band_lookup(input logic [30:0] freq);
    band_t b;
    logic  hit;
    b   = '0;
    hit = 1'b0;
    for (int j = 0; j < NUM_ROWS; j++) begin
      if (!hit && freq <= BAND_LIMIT[j]) begin
        hit     = 1'b1;
        b.vco   = BAND_VCO[j];
        b.cp    = 8'h10;
        b.gmp   = 2'h1;
        b.integ = 6'h00;
        b.prop  = (j == NUM_ROWS - 1) ? 6'h0E : 6'h0D;
      end
    end
    return b;
  endfunction

endpackage

// ===== rtl/pds_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by every division
// of the search. Depends on pds_pkg.
`timescale 1ns / 1ps
module pds_div
  import pds_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DVSR_W-1:0] rem_r;
  logic [DVSR_W-1:0] dvsr_r;
  logic [DIV_W-1:0]  q_r;
  logic [DVSR_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_r, q_r[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= CNT_W'(DIV_W - 1);
        rem_r  <= '0;
        dvsr_r <= req.divisor;
        q_r    <= req.dividend;
      end else if (busy_r) begin
        rem_r  <= fits ? DVSR_W'(rem_sh - {1'b0, dvsr_r}) : rem_sh[DVSR_W-1:0];
        q_r    <= {q_r[DIV_W-2:0], fits};
        done_r <= (cnt_r == '0);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/pll_divider_search_unit.sv =====
// Top level of the PLL divider search: request sequencer around one shared
// divider. Depends on pds_pkg and pds_div.
`timescale 1ns / 1ps
// One request at a time. Each division runs 44 steps on the shared serial
// divider. Three divisions set up the lane rate and the pre-divider range,
// each tried pre-divider costs one more, plus one for the voltage check when
// the feedback value is in range, and one more computes the Mbps figure if a
// solution was found. A 20 MHz reference tries 8 pre-dividers, a 200 MHz
// reference tries 76 and the largest reference tries 95. A request with no
// usable lane count or a zero reference goes straight to its result with no
// division. in_ready is high only while no request is being searched.
module pll_divider_search_unit
  import pds_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [27:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] in_pixel_clock_khz,
  input  logic [5:0]  in_bits_per_pixel,
  input  logic [2:0]  in_lane_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_no_solution,
  output logic [6:0]  out_input_div_code,
  output logic [9:0]  out_loop_div_code,
  output logic [30:0] out_actual_freq_hz,
  output logic [11:0] out_lane_rate_mbps,
  output logic [5:0]  out_vco_ctrl,
  output logic [7:0]  out_cp_bias_ctrl,
  output logic [1:0]  out_gmp_ctrl,
  output logic [5:0]  out_integral_ctrl,
  output logic [5:0]  out_proportional_ctrl
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_DLANE_GO, S_DLANE, S_DNMIN, S_DNMAX, S_NCHK,
    S_NDIV_GO, S_NDIVM, S_VDIV_GO, S_VDIV, S_MBPS_GO, S_MBPS, S_FIN
  } state_t;

  state_t           state_r;
  logic [27:0]      ref_clk_r;
  logic [2:0]       max_lanes_r;
  logic [19:0]      khz_r;
  logic [5:0]       bpp_r;
  logic [2:0]       lanes_r;
  logic [DIV_W-1:0] prod_r;
  logic [35:0]      fvco_r;
  logic [1:0]       post_sh_r;
  logic [7:0]       n_r;
  logic [7:0]       nmax_r;
  logic [9:0]       m_r;
  logic             found_r;
  logic [35:0]      best_err_r;
  logic [6:0]       best_n_r;
  logic [9:0]       best_m_r;
  logic [30:0]      best_hz_r;
  logic [11:0]      mbps_r;
  logic             out_valid_r;
  div_req_t         req_r;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] quot;

  logic [2:0]       lanes_sel;
  logic [2:0]       lanes_eff;
  logic [34:0]      fout;
  logic [1:0]       post_sh;
  logic [35:0]      err;
  logic [30:0]      v_freq;
  band_t            band;

  pds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    lanes_sel = (in_lane_count == 3'd0) ? max_lanes_r : in_lane_count;
    lanes_eff = (lanes_sel > 3'(MAX_LANES)) ? 3'(MAX_LANES) : lanes_sel;
    fout      = quot[35:1];
    if ({fout, 2'b00} < 37'(FVCO_LO))      post_sh = 2'd3;
    else if ({fout, 1'b0} < 36'(FVCO_LO))  post_sh = 2'd2;
    else if (fout < 35'(FVCO_LO))          post_sh = 2'd1;
    else                                   post_sh = 2'd0;
    err    = fvco_r - quot[35:0];
    v_freq = 31'(quot[35:0] >> post_sh_r);
    band   = band_lookup(best_hz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ref_clk_r   <= 28'd20000000;
      max_lanes_r <= 3'(MAX_LANES);
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      req_r       <= '0;
    end else begin
      if (req_r.start) req_r.start <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          REG_REF_CLK:   ref_clk_r   <= cfg_wdata;
          REG_MAX_LANES: max_lanes_r <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (state_r == S_FIN && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            khz_r   <= in_pixel_clock_khz;
            bpp_r   <= in_bits_per_pixel;
            lanes_r <= lanes_eff;
            found_r <= 1'b0;
            state_r <= (lanes_eff == 3'd0 || ref_clk_r == 28'd0) ? S_FIN : S_MUL1;
          end
        end
        S_MUL1: begin
          prod_r  <= DIV_W'(30'(khz_r) * 30'd1000);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r  <= DIV_W'(36'(prod_r[29:0]) * 36'(bpp_r));
          state_r <= S_DLANE_GO;
        end
        S_DLANE_GO: begin
          req_r   <= '{start: 1'b1, dividend: prod_r, divisor: DVSR_W'(lanes_r)};
          state_r <= S_DLANE;
        end
        S_DLANE: begin
          if (div_done) begin
            fvco_r    <= 36'({1'b0, fout} << post_sh);
            post_sh_r <= post_sh;
            req_r     <= '{start: 1'b1,
                          dividend: DIV_W'(ref_clk_r) + DIV_W'(NMIN_DIV) - 1'b1,
                          divisor: NMIN_DIV};
            state_r   <= S_DNMIN;
          end
        end
        S_DNMIN: begin
          if (div_done) begin
            n_r     <= quot[7:0];
            req_r   <= '{start: 1'b1, dividend: DIV_W'(ref_clk_r), divisor: NMAX_DIV};
            state_r <= S_DNMAX;
          end
        end
        S_DNMAX: begin
          if (div_done) begin
            nmax_r  <= (quot > DIV_W'(PREDIV_CAP)) ? PREDIV_CAP : quot[7:0];
            state_r <= S_NCHK;
          end
        end
        S_NCHK: begin
          if (n_r <= nmax_r) begin
            prod_r  <= DIV_W'(fvco_r) * DIV_W'(n_r);
            state_r <= S_NDIV_GO;
          end else begin
            state_r <= S_MBPS_GO;
          end
        end
        S_NDIV_GO: begin
          req_r   <= '{start: 1'b1, dividend: prod_r, divisor: ref_clk_r};
          state_r <= S_NDIVM;
        end
        S_NDIVM: begin
          if (div_done) begin
            if (quot >= MULT_LO && quot <= MULT_HI) begin
              m_r     <= quot[9:0];
              prod_r  <= DIV_W'(38'(quot[9:0]) * 38'(ref_clk_r));
              state_r <= S_VDIV_GO;
            end else begin
              n_r     <= n_r + 1'b1;
              state_r <= S_NCHK;
            end
          end
        end
        S_VDIV_GO: begin
          req_r   <= '{start: 1'b1, dividend: prod_r, divisor: DVSR_W'(n_r)};
          state_r <= S_VDIV;
        end
        S_VDIV: begin
          if (div_done) begin
            if (quot >= FVCO_LO && quot <= FVCO_HI && (!found_r || err < best_err_r)) begin
              found_r    <= 1'b1;
              best_err_r <= err;
              best_n_r   <= 7'(n_r - 1'b1);
              best_m_r   <= 10'(m_r - 2'd2);
              best_hz_r  <= v_freq;
            end
            n_r     <= n_r + 1'b1;
            state_r <= S_NCHK;
          end
        end
        S_MBPS_GO: begin
          if (found_r) begin
            req_r   <= '{start: 1'b1,
                        dividend: DIV_W'({best_hz_r, 1'b0}) + DIV_W'(MHZ) - 1'b1,
                        divisor: MHZ};
            state_r <= S_MBPS;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_MBPS: begin
          if (div_done) begin
            mbps_r  <= quot[11:0];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_no_solution       <= !found_r;
            out_input_div_code    <= found_r ? best_n_r : '0;
            out_loop_div_code     <= found_r ? best_m_r : '0;
            out_actual_freq_hz    <= found_r ? best_hz_r : '0;
            out_lane_rate_mbps    <= found_r ? mbps_r : '0;
            out_vco_ctrl          <= found_r ? band.vco : '0;
            out_cp_bias_ctrl      <= found_r ? band.cp : '0;
            out_gmp_ctrl          <= found_r ? band.gmp : '0;
            out_integral_ctrl     <= found_r ? band.integ : '0;
            out_proportional_ctrl <= found_r ? band.prop : '0;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy) else $error("divider busy while idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  a_nosol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_solution) |-> (out_input_div_code == 7'd0 &&
      out_loop_div_code == 10'd0 && out_actual_freq_hz == 31'd0))
    else $error("fields set without solution");
  a_loop_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_no_solution) |-> (out_loop_div_code >= 10'd62 &&
      out_loop_div_code <= 10'd623)) else $error("loop divider out of range");

endmodule
